/* rtl/core/pefs_pkg.sv */
// Shared types, codes and defaults for the polygon edge fragment shifter.
package pefs_pkg;

  // Fixed field widths of the channels and configuration port
  localparam int VTX_W      = 32;
  localparam int STEP_W     = 20;
  localparam int SHIFT_W    = 20;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;
  localparam int KIND_W     = 2;

  // Parameter defaults
  localparam int MAX_POINTS_DEF  = 10;
  localparam int COORD_WIDTH_DEF = 32;

  // Configuration reset values
  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(500);
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(50);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_DISTANCE = CFG_IDX_W'(1);

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_FRAG  = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_SHIFT = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_MOVE  = KIND_W'(2);

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef struct packed {
    logic neg;
    logic zero;
  } alu_flags_t;

endpackage

/* rtl/core/pefs_vtx_if.sv */
// Vertex request channel: valid/ready plus vertex payload.
interface pefs_vtx_if;
  logic                              valid;
  logic                              ready;
  logic signed [pefs_pkg::VTX_W-1:0] vertex_x;
  logic signed [pefs_pkg::VTX_W-1:0] vertex_y;
  logic                              last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                output ready);
endinterface

/* rtl/core/pefs_pt_if.sv */
// Point result channel: valid/ready plus point payload.
interface pefs_pt_if;
  logic                               valid;
  logic                               ready;
  logic signed [pefs_pkg::VTX_W-1:0]  point_x;
  logic signed [pefs_pkg::VTX_W-1:0]  point_y;
  logic        [pefs_pkg::KIND_W-1:0] point_kind;
  logic                               last_of_run;
  logic                               last_of_polygon;
  logic                               clipped;

  modport source (output valid, output point_x, output point_y, output point_kind,
                  output last_of_run, output last_of_polygon, output clipped,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input point_kind,
                input last_of_run, input last_of_polygon, input clipped,
                output ready);
endinterface

/* rtl/core/pefs_alu.sv */
// Shared add/subtract unit with sign and zero flags.
module pefs_alu #(
  parameter int W = 34
) (
  input  pefs_pkg::alu_op_e    op_i,
  input  logic [W-1:0]         a_i,
  input  logic [W-1:0]         b_i,
  output logic [W-1:0]         sum_o,
  output pefs_pkg::alu_flags_t flags_o
);
  import pefs_pkg::*;

  always_comb begin
    unique case (op_i)
      ALU_ADD: sum_o = a_i + b_i;
      ALU_SUB: sum_o = a_i - b_i;
      default: sum_o = a_i + b_i;
    endcase
    flags_o.neg  = sum_o[W-1];
    flags_o.zero = (sum_o == '0);
  end

endmodule

/* rtl/core/polygon_edge_fragment_shift.sv */
// Top level: edge sequencer around one shared adder, emitting fragment points.
// Sequence: a first vertex that is not the polygon's last is stored and gives no results.
// Each edge runs EDGE_DIFF, EDGE_ABS, EDGE_CLIP, then per fragment point PT_OFF, PT_REM,
// PT_NXT on the single shared adder, then EMIT_P, EMIT_S, EMIT_M, held while ready is low.
// Throughput: one vertex at a time; ready is high only between items.
// Reset: polygon state and parity cleared, step_size 500, shift_distance 50.
module polygon_edge_fragment_shift #(
  parameter int MAX_POINTS_PER_EDGE = pefs_pkg::MAX_POINTS_DEF,
  parameter int COORD_WIDTH         = pefs_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pefs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pefs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  pefs_vtx_if.sink                         vtx_i,
  pefs_pt_if.source                        pt_o
);
  import pefs_pkg::*;

  localparam int CW      = (COORD_WIDTH > VTX_W) ? VTX_W : COORD_WIDTH;
  localparam int KW      = $clog2(MAX_POINTS_PER_EDGE + 1);
  localparam int AluW    = (CW + 2 > STEP_W + KW + 1) ? CW + 2 : STEP_W + KW + 1;
  localparam longint CoordHi = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint CoordLo = -CoordHi - 1;

  typedef enum logic [3:0] {
    IDLE, EDGE_DIFF, EDGE_ABS, EDGE_CLIP, PT_OFF, PT_REM, PT_NXT, EMIT_P, EMIT_S, EMIT_M
  } state_e;

  state_e state_q;

  logic [STEP_W-1:0]  step_q;
  logic [SHIFT_W-1:0] shift_q;

  logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [CW-1:0] cur_q, perp_q, sh_q, mv_q;
  logic [AluW-1:0]      dist_q, rem_q;
  logic [KW-1:0]        k_q;
  logic in_poly_q, parity_q, close_pend_q, is_close_q;
  logic vert_q, dir_neg_q, edge_clip_q, sh_clip_q, has_next_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_RESET;
      shift_q <= SHIFT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_STEP_SIZE) begin
        step_q <= STEP_W'(cfg_data_i);
      end else if (cfg_idx_i == CFG_SHIFT_DISTANCE) begin
        shift_q <= SHIFT_W'(cfg_data_i);
      end
    end
  end

  logic [STEP_W-1:0] s_eff;
  assign s_eff = (step_q == '0) ? STEP_W'(1) : step_q;

  // input saturation to the coordinate range
  logic signed [CW-1:0] vx, vy;
  always_comb begin
    if ($signed(vtx_i.vertex_x) > CoordHi)      vx = CW'(CoordHi);
    else if ($signed(vtx_i.vertex_x) < CoordLo) vx = CW'(CoordLo);
    else                                        vx = CW'(vtx_i.vertex_x);
    if ($signed(vtx_i.vertex_y) > CoordHi)      vy = CW'(CoordHi);
    else if ($signed(vtx_i.vertex_y) < CoordLo) vy = CW'(CoordLo);
    else                                        vy = CW'(vtx_i.vertex_y);
  end

  // shared adder operand select
  alu_op_e         alu_op;
  logic [AluW-1:0] alu_a, alu_b, alu_sum;
  alu_flags_t      alu_flags;
  logic            vert_w;

  assign vert_w = (ax_q == bx_q);

  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_q)
      EDGE_DIFF: begin
        alu_op = ALU_SUB;
        alu_a  = vert_w ? AluW'(by_q) : AluW'(bx_q);
        alu_b  = vert_w ? AluW'(ay_q) : AluW'(ax_q);
      end
      EDGE_ABS: begin
        alu_op = dir_neg_q ? ALU_SUB : ALU_ADD;
        alu_a  = dir_neg_q ? '0 : dist_q;
        alu_b  = dir_neg_q ? dist_q : '0;
      end
      EDGE_CLIP: begin
        alu_op = ALU_SUB;
        alu_a  = dist_q;
        alu_b  = AluW'(MAX_POINTS_PER_EDGE) * AluW'(s_eff);
      end
      PT_OFF: begin
        alu_op = parity_q ? ALU_SUB : ALU_ADD;
        alu_a  = AluW'(perp_q);
        alu_b  = AluW'(shift_q);
      end
      PT_REM: begin
        alu_op = ALU_SUB;
        alu_a  = rem_q;
        alu_b  = AluW'(s_eff);
      end
      PT_NXT: begin
        alu_op = dir_neg_q ? ALU_SUB : ALU_ADD;
        alu_a  = AluW'(cur_q);
        alu_b  = AluW'(s_eff);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  pefs_alu #(.W(AluW)) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sum_o   (alu_sum),
    .flags_o (alu_flags)
  );

  logic signed [CW-1:0] sat_val;
  logic                 sat_hit;
  always_comb begin
    sat_hit = 1'b1;
    if ($signed(alu_sum) > CoordHi)      sat_val = CW'(CoordHi);
    else if ($signed(alu_sum) < CoordLo) sat_val = CW'(CoordLo);
    else begin
      sat_val = alu_sum[CW-1:0];
      sat_hit = 1'b0;
    end
  end

  logic k_ok;
  assign k_ok = (k_q + KW'(1)) < KW'(MAX_POINTS_PER_EDGE);

  logic last_run;
  assign last_run = !has_next_q && !close_pend_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= IDLE;
      in_poly_q    <= 1'b0;
      parity_q     <= 1'b0;
      close_pend_q <= 1'b0;
      is_close_q   <= 1'b0;
      first_x_q    <= '0;
      first_y_q    <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      k_q          <= '0;
      has_next_q   <= 1'b0;
    end else begin
      unique case (state_q)
        IDLE: begin
          if (vtx_i.valid) begin
            in_poly_q <= !vtx_i.last_vertex;
            prev_x_q  <= vx;
            prev_y_q  <= vy;
            if (!in_poly_q) begin
              first_x_q <= vx;
              first_y_q <= vy;
              parity_q  <= 1'b0;
              if (vtx_i.last_vertex) begin
                // lone vertex: closing edge of zero length
                ax_q         <= vx;
                ay_q         <= vy;
                bx_q         <= vx;
                by_q         <= vy;
                close_pend_q <= 1'b0;
                is_close_q   <= 1'b1;
                state_q      <= EDGE_DIFF;
              end
            end else begin
              ax_q         <= prev_x_q;
              ay_q         <= prev_y_q;
              bx_q         <= vx;
              by_q         <= vy;
              close_pend_q <= vtx_i.last_vertex;
              is_close_q   <= 1'b0;
              state_q      <= EDGE_DIFF;
            end
          end
        end
        EDGE_DIFF: begin
          vert_q    <= vert_w;
          cur_q     <= vert_w ? ay_q : ax_q;
          perp_q    <= vert_w ? ax_q : ay_q;
          dist_q    <= alu_sum;
          dir_neg_q <= alu_flags.neg;
          state_q   <= EDGE_ABS;
        end
        EDGE_ABS: begin
          dist_q  <= alu_sum;
          state_q <= EDGE_CLIP;
        end
        EDGE_CLIP: begin
          edge_clip_q <= !alu_flags.neg && !alu_flags.zero;
          rem_q       <= dist_q;
          k_q         <= '0;
          state_q     <= PT_OFF;
        end
        PT_OFF: begin
          sh_q      <= sat_val;
          sh_clip_q <= edge_clip_q || sat_hit;
          state_q   <= PT_REM;
        end
        PT_REM: begin
          rem_q      <= alu_sum;
          has_next_q <= k_ok && !alu_flags.neg && !alu_flags.zero;
          state_q    <= PT_NXT;
        end
        PT_NXT: begin
          // coordinate of the following point: the next fragment point, or else the edge end
          if (has_next_q) mv_q <= alu_sum[CW-1:0];
          else            mv_q <= vert_q ? by_q : bx_q;
          state_q <= EMIT_P;
        end
        EMIT_P: begin
          if (pt_o.ready) state_q <= EMIT_S;
        end
        EMIT_S: begin
          if (pt_o.ready) state_q <= EMIT_M;
        end
        EMIT_M: begin
          if (pt_o.ready) begin
            parity_q <= ~parity_q;
            if (has_next_q) begin
              cur_q   <= mv_q;
              k_q     <= k_q + KW'(1);
              state_q <= PT_OFF;
            end else if (close_pend_q) begin
              ax_q         <= prev_x_q;
              ay_q         <= prev_y_q;
              bx_q         <= first_x_q;
              by_q         <= first_y_q;
              close_pend_q <= 1'b0;
              is_close_q   <= 1'b1;
              state_q      <= EDGE_DIFF;
            end else begin
              state_q <= IDLE;
            end
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign vtx_i.ready = (state_q == IDLE);

  // result mux
  always_comb begin
    pt_o.valid           = 1'b0;
    pt_o.point_x         = VTX_W'(vert_q ? perp_q : cur_q);
    pt_o.point_y         = VTX_W'(vert_q ? cur_q : perp_q);
    pt_o.point_kind      = KIND_FRAG;
    pt_o.last_of_run     = 1'b0;
    pt_o.last_of_polygon = 1'b0;
    pt_o.clipped         = edge_clip_q;
    unique case (state_q)
      EMIT_P: begin
        pt_o.valid = 1'b1;
      end
      EMIT_S: begin
        pt_o.valid      = 1'b1;
        pt_o.point_x    = VTX_W'(vert_q ? sh_q : cur_q);
        pt_o.point_y    = VTX_W'(vert_q ? cur_q : sh_q);
        pt_o.point_kind = KIND_SHIFT;
        pt_o.clipped    = sh_clip_q;
      end
      EMIT_M: begin
        pt_o.valid           = 1'b1;
        pt_o.point_x         = VTX_W'(vert_q ? sh_q : mv_q);
        pt_o.point_y         = VTX_W'(vert_q ? mv_q : sh_q);
        pt_o.point_kind      = KIND_MOVE;
        pt_o.clipped         = sh_clip_q;
        pt_o.last_of_run     = last_run;
        pt_o.last_of_polygon = last_run && is_close_q;
      end
      default: begin
        pt_o.valid = 1'b0;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_o.valid |-> !vtx_i.ready)
    else $error("result offered while taking a vertex");

  a_run_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_o.valid && pt_o.ready && pt_o.last_of_run) |=> vtx_i.ready)
    else $error("not ready after last result of a vertex");

  a_poly_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pt_o.valid && pt_o.last_of_polygon) |-> (pt_o.last_of_run && !in_poly_q))
    else $error("polygon end outside a closing run");

  a_k_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_o.valid |-> (k_q < KW'(MAX_POINTS_PER_EDGE)))
    else $error("fragment index beyond edge limit");

endmodule
